### rtl/core/flvtd_pkg.sv
// Shared constants and types for the FLV tag deframer.
package flvtd_pkg;

   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned CSR_ADDR_W = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EXPECT_FILE_HEADER = 1'b0,
      CSR_STRIP_CODEC_PREFIX = 1'b1
   } csr_addr_type;

   typedef enum logic [1:0] {
      KIND_DESCRIPTOR = 2'd0,
      KIND_PAYLOAD    = 2'd1,
      KIND_BAD_MAGIC  = 2'd2,
      KIND_HEADER_OK  = 2'd3
   } kind_type;

   localparam logic [7:0] MAGIC_F   = 8'h46;
   localparam logic [7:0] MAGIC_L   = 8'h4C;
   localparam logic [7:0] MAGIC_V   = 8'h56;
   localparam logic [7:0] TAG_AUDIO = 8'h08;
   localparam logic [7:0] TAG_VIDEO = 8'h09;

   localparam logic [31:0] FILE_HDR_LEN   = 32'd9;
   localparam logic [24:0] TAG_HDR_EXTRA  = 25'd11;
   localparam logic [31:0] TAG_HDR_LAST   = 32'd14;

   localparam logic [3:0] AUDIO_AAC   = 4'd10;
   localparam logic [3:0] VIDEO_VP6   = 4'd4;
   localparam logic [3:0] VIDEO_VP6A  = 4'd5;
   localparam logic [3:0] VIDEO_H264  = 4'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic        prev_size_ok;
      logic [7:0]  payload_byte;
      logic        stereo;
      logic        wide_samples;
      logic [1:0]  rate_code;
      logic [3:0]  frame_type;
      logic [3:0]  codec_id;
      logic [23:0] payload_len;
      logic [23:0] time_ms;
      logic        audio_tag;
   } rsp_item_type;

endpackage

### rtl/core/flv_tag_deframer_unit.sv
// FLV tag deframer: header and tag parser with a registered result stage.
//
// Usage: the FLV stream enters one byte per req transaction (req_tdata holds
// the byte, req_tuser requests a restart of the parser before that byte).
// Each byte yields at most one rsp transaction: a tag descriptor, a payload
// byte, a bad-magic report or a header-accepted report (rsp_tuser).
// rsp_tlast marks the final payload byte of a tag, or a descriptor with no
// payload.
// Throughput: one byte per clock. Each byte is parsed in the cycle it is
// accepted and its result is registered.
// The single result register sets the rate: while it holds a result that
// the receiver does not take, req_tready is low; when it is taken, a new
// byte is accepted in that same cycle.
// Reset clears the parser to stream start and sets both csr registers to 1.
// csr writes are taken at any edge with csr_we high outside reset; expect_file_header
// acts at the next restart (reset sets it to 1), strip_codec_prefix at each flags byte.
module flv_tag_deframer_unit
   import flvtd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tuser,   // restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // audio_tag, time_ms, payload_len,
                                              // codec_id, frame_type, rate_code,
                                              // wide_samples, stereo,
                                              // payload_byte, prev_size_ok, pad
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic                  csr_wdata
);

   typedef enum logic [2:0] {
      PH_FILEHDR, PH_SKIPOFF, PH_TAGHDR, PH_FLAGS, PH_DATA, PH_SKIPTAG, PH_HALT
   } phase_type;

   logic         expect_hdr_ff, strip_prefix_ff;
   phase_type    phase_ff, phase_in;
   logic [31:0]  byte_count_ff, byte_count_in;
   logic [7:0]   tag_kind_ff, tag_kind_in;
   logic [23:0]  tag_size_ff, tag_size_in;
   logic [23:0]  tag_time_ff, tag_time_in;
   logic [31:0]  prev_field_ff, prev_field_in;
   logic [24:0]  expected_prev_ff, expected_prev_in;
   logic [31:0]  header_offset_ff, header_offset_in;
   logic [2:0]   prefix_left_ff, prefix_left_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_load;
   logic         accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_type   ph;
      logic [31:0] bc;
      logic [7:0]  b;
      logic [23:0] remain;
      logic [2:0]  pre;
      logic [23:0] plen;
      logic        audio;

      b  = req_tdata;
      ph = phase_ff;
      bc = byte_count_ff;
      tag_kind_in      = tag_kind_ff;
      tag_size_in      = tag_size_ff;
      tag_time_in      = tag_time_ff;
      prev_field_in    = prev_field_ff;
      expected_prev_in = expected_prev_ff;
      header_offset_in = header_offset_ff;
      prefix_left_in   = prefix_left_ff;
      if (req_tuser) begin
         ph = expect_hdr_ff ? PH_FILEHDR : PH_TAGHDR;
         bc = '0;
         tag_kind_in      = '0;
         tag_size_in      = '0;
         tag_time_in      = '0;
         prev_field_in    = '0;
         expected_prev_in = '0;
         header_offset_in = '0;
         prefix_left_in   = '0;
      end
      phase_in      = ph;
      byte_count_in = bc;
      rsp_in        = '0;
      rsp_load      = 1'b0;
      audio         = (tag_kind_in == TAG_AUDIO);
      remain        = tag_size_in - 24'd1;
      pre           = 3'd0;
      plen          = '0;

      case (ph)
         PH_FILEHDR: begin
            if (bc < 32'd2) begin
               prev_field_in = {prev_field_in[23:0], b};
            end else if (bc == 32'd2) begin
               if (prev_field_in[15:0] != {MAGIC_F, MAGIC_L} || b != MAGIC_V) begin
                  phase_in    = PH_HALT;
                  rsp_in.kind = KIND_BAD_MAGIC;
                  rsp_load    = 1'b1;
               end
               prev_field_in = '0;
            end else if (bc >= 32'd5) begin
               header_offset_in = {header_offset_in[23:0], b};
            end
            if (phase_in != PH_HALT) begin
               if (bc == 32'd8) begin
                  if (header_offset_in > FILE_HDR_LEN) begin
                     byte_count_in = header_offset_in - FILE_HDR_LEN;
                     phase_in      = PH_SKIPOFF;
                  end else begin
                     byte_count_in = '0;
                     phase_in      = PH_TAGHDR;
                  end
                  rsp_in.kind = KIND_HEADER_OK;
                  rsp_load    = 1'b1;
               end else begin
                  byte_count_in = bc + 32'd1;
               end
            end
         end
         PH_SKIPOFF, PH_SKIPTAG: begin
            byte_count_in = bc - 32'd1;
            if (byte_count_in == '0) phase_in = PH_TAGHDR;
         end
         PH_TAGHDR: begin
            if (bc < 32'd4)       prev_field_in = {prev_field_in[23:0], b};
            else if (bc == 32'd4) tag_kind_in   = b;
            else if (bc < 32'd8)  tag_size_in   = {tag_size_in[15:0], b};
            else if (bc < 32'd11) tag_time_in   = {tag_time_in[15:0], b};
            if (bc < TAG_HDR_LAST) begin
               byte_count_in = bc + 32'd1;
            end else begin
               byte_count_in = '0;
               if (tag_size_in != '0 &&
                   (tag_kind_in == TAG_AUDIO || tag_kind_in == TAG_VIDEO)) begin
                  phase_in = PH_FLAGS;
               end else begin
                  expected_prev_in = {1'b0, tag_size_in} + TAG_HDR_EXTRA;
                  if (tag_size_in != '0) begin
                     byte_count_in = {8'd0, tag_size_in};
                     phase_in      = PH_SKIPTAG;
                  end
               end
            end
         end
         PH_FLAGS: begin
            if (strip_prefix_ff) begin
               if (audio) begin
                  if (b[7:4] == AUDIO_AAC) pre = 3'd1;
               end else if (b[3:0] == VIDEO_VP6 || b[3:0] == VIDEO_VP6A) begin
                  pre = 3'd1;
               end else if (b[3:0] == VIDEO_H264) begin
                  pre = 3'd4;
               end
            end
            plen = (remain > {21'd0, pre}) ? remain - {21'd0, pre} : '0;
            rsp_in.kind         = KIND_DESCRIPTOR;
            rsp_in.audio_tag    = audio;
            rsp_in.time_ms      = tag_time_in;
            rsp_in.payload_len  = plen;
            if (audio) begin
               rsp_in.codec_id     = b[7:4];
               rsp_in.rate_code    = b[3:2];
               rsp_in.wide_samples = b[1];
               rsp_in.stereo       = b[0];
            end else begin
               rsp_in.codec_id   = b[3:0];
               rsp_in.frame_type = b[7:4];
            end
            rsp_in.last         = (plen == '0);
            rsp_in.prev_size_ok = (prev_field_in == {7'd0, expected_prev_in});
            rsp_load            = 1'b1;
            expected_prev_in    = {1'b0, tag_size_in} + TAG_HDR_EXTRA;
            prefix_left_in      = pre;
            byte_count_in       = {8'd0, remain};
            phase_in            = (remain == '0) ? PH_TAGHDR : PH_DATA;
         end
         PH_DATA: begin
            byte_count_in = bc - 32'd1;
            if (byte_count_in == '0) phase_in = PH_TAGHDR;
            if (prefix_left_in != '0) begin
               prefix_left_in = prefix_left_in - 3'd1;
            end else begin
               rsp_in.kind         = KIND_PAYLOAD;
               rsp_in.payload_byte = b;
               rsp_in.last         = (byte_count_in == '0);
               rsp_load            = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_hdr_ff    <= 1'b1;
         strip_prefix_ff  <= 1'b1;
         phase_ff         <= PH_FILEHDR;
         byte_count_ff    <= '0;
         tag_kind_ff      <= '0;
         tag_size_ff      <= '0;
         tag_time_ff      <= '0;
         prev_field_ff    <= '0;
         expected_prev_ff <= '0;
         header_offset_ff <= '0;
         prefix_left_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_EXPECT_FILE_HEADER: expect_hdr_ff   <= csr_wdata;
               CSR_STRIP_CODEC_PREFIX: strip_prefix_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            byte_count_ff    <= byte_count_in;
            tag_kind_ff      <= tag_kind_in;
            tag_size_ff      <= tag_size_in;
            tag_time_ff      <= tag_time_in;
            prev_field_ff    <= prev_field_in;
            expected_prev_ff <= expected_prev_in;
            header_offset_ff <= header_offset_in;
            prefix_left_ff   <= prefix_left_in;
         end
         if (accept && rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {2'b00, rsp_ff.prev_size_ok, rsp_ff.payload_byte, rsp_ff.stereo,
                        rsp_ff.wide_samples, rsp_ff.rate_code, rsp_ff.frame_type,
                        rsp_ff.codec_id, rsp_ff.payload_len, rsp_ff.time_ms,
                        rsp_ff.audio_tag};

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tuser && phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("parser left halt without restart");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIPOFF || phase_ff == PH_SKIPTAG || phase_ff == PH_DATA)
      |-> (byte_count_ff != '0))
      else $error("byte count exhausted inside a counted phase");

   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      prefix_left_ff <= 3'd4)
      else $error("codec prefix count out of range");

   a_desc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DESCRIPTOR)
      |-> (rsp_tlast == (rsp_ff.payload_len == '0)))
      else $error("descriptor last flag disagrees with payload length");

endmodule
